>>> sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants for the DER time parser
// Tag codes, byte and length constants, status codes, and the tracker
// snapshot that passes from the state tracker to the result stage.
// ----------------------------------------------------------------------------
package dtc_pkg;

  // DER tags of the two time types
  localparam logic [7:0] TagUtcTime = 8'h17;
  localparam logic [7:0] TagGenTime = 8'h18;

  // ASCII codes
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiFive = 8'h35;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiZ    = 8'h5A;

  // Byte counter limits and value lengths
  localparam int unsigned CountW    = 5;
  localparam logic [CountW-1:0] CountSat  = 5'd16;
  localparam logic [CountW-1:0] AccDigits = 5'd14;
  localparam logic [CountW-1:0] LenUtc    = 5'd13;
  localparam logic [CountW-1:0] LenGen    = 5'd15;

  // Timestamp width and century offsets (century * 10^10)
  localparam int unsigned TsW = 47;
  localparam logic [TsW-1:0] Base1900 = 47'd19000000000000;
  localparam logic [TsW-1:0] Base2000 = 47'd20000000000000;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadFormat = 2'd1,
    StBadTag    = 2'd2
  } status_e;

  // Next-state view of the tracker for the beat being accepted
  typedef struct packed {
    logic [7:0]        tag;
    logic [CountW-1:0] count;
    logic [7:0]        latest;
    logic              prior_digits;
    logic              high_year;
    logic [TsW-1:0]    acc;
  } track_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= AsciiZero) && (b <= AsciiNine);
  endfunction

endpackage

>>> sv/dtc_if.sv
// ----------------------------------------------------------------------------
// dtc_in_if / dtc_out_if: valid/ready channels of the DER time parser
// Input channel carries at most one content octet per beat; output
// channel carries the status and canonical timestamp.
// ----------------------------------------------------------------------------
interface dtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, tag_byte, data_byte, byte_present, last_item,
                  input ready);
  modport sink   (input valid, tag_byte, data_byte, byte_present, last_item,
                  output ready);
endinterface

interface dtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [46:0] timestamp;

  modport source (output valid, status, timestamp, input ready);
  modport sink   (input valid, status, timestamp, output ready);
endinterface

>>> sv/der_time_to_canonical_core.sv
// ----------------------------------------------------------------------------
// der_time_to_canonical_core: DER UTCTime/GeneralizedTime parser
// Streams content octets and gives one status/timestamp beat per value.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------
//   in_i    | in  | tag_byte, data_byte, byte_present, last_item
//   out_o   | out | status, timestamp
//
// One input beat per cycle while in_i.ready is high; the result appears in
// the cycle after the beat that carries last_item, from the output register.
// Input ready falls only while a result is held and out_o.ready is low.
// Reset clears the tracker state and the output valid.
// ----------------------------------------------------------------------------
module der_time_to_canonical_core
  import dtc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  dtc_in_if.sink    in_i,
  dtc_out_if.source out_o
);

  logic    accept;
  track_t  next_st;
  status_e status;

  // Accept whenever the output register is free or being emptied
  assign in_i.ready = !out_o.valid || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  dtc_track u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .tag_byte_i     (in_i.tag_byte),
    .data_byte_i    (in_i.data_byte),
    .byte_present_i (in_i.byte_present),
    .last_item_i    (in_i.last_item),
    .next_o         (next_st)
  );

  dtc_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && in_i.last_item),
    .next_i      (next_st),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (status),
    .timestamp_o (out_o.timestamp)
  );

  assign out_o.status = status;

  // A last beat always yields a result beat in the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_item) |=> out_o.valid)
    else $error("no result after last beat");

  // Failed values carry a zero timestamp
  a_fail_zero_ts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != StOk)) |-> (out_o.timestamp == '0))
    else $error("nonzero timestamp on failed value");

  // A stalled result beat keeps its payload until taken
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.status)
                                       && $stable(out_o.timestamp)))
    else $error("result beat changed while stalled");

  // No status code beyond bad tag
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.status == StOk) || (out_o.status == StBadFormat)
                     || (out_o.status == StBadTag)))
    else $error("illegal status code");

endmodule

>>> sv/dtc_track.sv
// ----------------------------------------------------------------------------
// dtc_track: per-value state tracker
// Latches the tag, counts octets, folds digits into the accumulator and
// tracks digit-ness of earlier octets. Clears itself at the last beat.
// ----------------------------------------------------------------------------
module dtc_track
  import dtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] tag_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       last_item_i,
  output track_t     next_o
);

  logic [7:0]        tag_q, tag_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        latest_q, latest_d;
  logic              prior_q, prior_d;
  logic              high_year_q, high_year_d;
  logic [TsW-1:0]    acc_q, acc_d;
  logic              digit;

  assign digit = is_digit(data_byte_i);

  // Next-state for one beat
  always_comb begin
    tag_d       = (count_q == '0) ? tag_byte_i : tag_q;
    count_d     = count_q;
    latest_d    = latest_q;
    prior_d     = prior_q;
    high_year_d = high_year_q;
    acc_d       = acc_q;
    if (byte_present_i) begin
      if ((count_q != '0) && !is_digit(latest_q)) begin
        prior_d = 1'b0;
      end
      if ((count_q < AccDigits) && digit) begin
        // acc * 10 + digit, as shift-and-add
        acc_d = {acc_q[TsW-4:0], 3'b000} + {acc_q[TsW-2:0], 1'b0}
              + {{(TsW-4){1'b0}}, data_byte_i[3:0]};
      end
      if (count_q == '0) begin
        high_year_d = (data_byte_i >= AsciiFive);
      end
      latest_d = data_byte_i;
      if (count_q < CountSat) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  assign next_o = '{tag: tag_d, count: count_d, latest: latest_d,
                    prior_digits: prior_d, high_year: high_year_d, acc: acc_d};

  // State registers; back to reset values after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      count_q     <= '0;
      latest_q    <= '0;
      prior_q     <= 1'b1;
      high_year_q <= 1'b0;
      acc_q       <= '0;
    end else if (accept_i) begin
      if (last_item_i) begin
        tag_q       <= '0;
        count_q     <= '0;
        latest_q    <= '0;
        prior_q     <= 1'b1;
        high_year_q <= 1'b0;
        acc_q       <= '0;
      end else begin
        tag_q       <= tag_d;
        count_q     <= count_d;
        latest_q    <= latest_d;
        prior_q     <= prior_d;
        high_year_q <= high_year_d;
        acc_q       <= acc_d;
      end
    end
  end

endmodule

>>> sv/dtc_result.sv
// ----------------------------------------------------------------------------
// dtc_result: format check and output register
// Judges the finished value and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module dtc_result
  import dtc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  track_t         next_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output status_e        status_o,
  output logic [TsW-1:0] timestamp_o
);

  logic           valid_q, valid_d;
  status_e        status_q, status_d;
  logic [TsW-1:0] ts_q, ts_d;
  logic           form_ok;

  // Shared 'Z' terminator and all-digit check
  assign form_ok = (next_i.latest == AsciiZ) && next_i.prior_digits;

  // Status and timestamp; an ok UTC value has its year digits in the top
  // of the accumulator, so adding the century offset gives the full year
  always_comb begin
    status_d = StBadTag;
    ts_d     = '0;
    if (next_i.tag == TagUtcTime) begin
      if (form_ok && (next_i.count == LenUtc)) begin
        status_d = StOk;
        ts_d     = next_i.acc + (next_i.high_year ? Base1900 : Base2000);
      end else begin
        status_d = StBadFormat;
      end
    end else if (next_i.tag == TagGenTime) begin
      if (form_ok && (next_i.count == LenGen)) begin
        status_d = StOk;
        ts_d     = next_i.acc;
      end else begin
        status_d = StBadFormat;
      end
    end
  end

  assign valid_d = (valid_q && !out_ready_i) || load_i;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_d;
      ts_q     <= ts_d;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign timestamp_o = ts_q;

endmodule

>>> test/tb_der_time_to_canonical_core.sv
// ----------------------------------------------------------------------------
// tb_der_time_to_canonical_core: self-checking bench for the DER time parser
// Streams UTCTime and GeneralizedTime values through the input channel. A
// directed table comes first, then mostly well-formed random values mixed
// with broken ones and noise. Typed directed rows carry their expected beat;
// a behavioral tracker predicts the others. A monitor checks every output
// beat against them. Both channels idle at random, and the receiver holds
// off once for a long stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_der_time_to_canonical_core;
  import dtc_pkg::*;

  localparam int unsigned BeatTarget = 1400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAt     = 500;
  localparam int unsigned QuietTail  = 150;
  localparam logic [TsW-1:0] TenPow10 = 47'd10000000000;

  typedef struct packed {
    status_e        status;
    logic [TsW-1:0] stamp;
  } stamp_t;

  // One directed value; typed rows carry their expected beat
  typedef struct {
    logic [7:0]     tag;
    bit             lead;
    string          text;
    bit             trail;
    bit             typed;
    status_e        status;
    logic [TsW-1:0] stamp;
  } row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dtc_in_if  in_if ();
  dtc_out_if out_if ();

  der_time_to_canonical_core DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Tracker mirror of the parser state
  logic [CountW-1:0] octet_cnt    = '0;
  logic [TsW-1:0]    digit_acc    = '0;
  bit                prior_dig_ok = 1'b1;
  logic [7:0]        latest_oct   = '0;
  logic [7:0]        value_tag    = '0;

  stamp_t      stamp_q[$];
  stamp_t      want;
  int unsigned beats_sent = 0;
  int unsigned cycles     = 0;
  int unsigned errors     = 0;
  bit          idle_on    = 1'b1;
  bit          hold_req   = 1'b0;

  row_t dir_rows [14] = '{
    '{TagUtcTime, 1'b0, "",                 1'b1, 1'b1, StBadFormat, 47'd0},
    '{8'h00,      1'b0, "",                 1'b1, 1'b1, StBadTag,    47'd0},
    '{8'hFF,      1'b0, "491231235959Z",    1'b0, 1'b1, StBadTag,    47'd0},
    '{TagUtcTime, 1'b0, "491231235959Z",    1'b0, 1'b1, StOk,  47'd20491231235959},
    '{TagUtcTime, 1'b0, "500101000000Z",    1'b0, 1'b1, StOk,  47'd19500101000000},
    '{TagUtcTime, 1'b1, "000000000000Z",    1'b1, 1'b0, StOk,        47'd0},
    '{TagGenTime, 1'b0, "99999999999999Z",  1'b0, 1'b1, StOk,  47'd99999999999999},
    '{TagGenTime, 1'b0, "00000000000000Z",  1'b0, 1'b1, StOk,        47'd0},
    '{TagGenTime, 1'b0, "999912312359590Z", 1'b0, 1'b1, StBadFormat, 47'd0},
    '{TagUtcTime, 1'b0, "4912312359590",    1'b0, 1'b1, StBadFormat, 47'd0},
    '{TagUtcTime, 1'b0, "49A231235959Z",    1'b0, 1'b1, StBadFormat, 47'd0},
    '{TagGenTime, 1'b0, "991231235959Z",    1'b0, 1'b1, StBadFormat, 47'd0},
    '{TagUtcTime, 1'b0, "49123123Z959Z",    1'b0, 1'b1, StBadFormat, 47'd0},
    '{TagGenTime, 1'b1, "19991231235959Z",  1'b1, 1'b0, StOk,        47'd0}
  };

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fold one beat into the tracker; yields a result on the last beat
  task automatic predict_stamp(input logic [7:0] tag, input logic [7:0] data,
                               input bit pres, input bit last,
                               output bit made, output stamp_t res);
    longint unsigned yy;
    longint unsigned year;
    bit              data_dig;
    bit              prev_dig;
    made       = 1'b0;
    res.status = StOk;
    res.stamp  = '0;
    data_dig   = (data >= AsciiZero) && (data <= AsciiNine);
    prev_dig   = (latest_oct >= AsciiZero) && (latest_oct <= AsciiNine);
    // tag is latched until the first octet is counted
    if (octet_cnt == '0) value_tag = tag;
    if (pres) begin
      if (octet_cnt != '0 && !prev_dig) prior_dig_ok = 1'b0;
      if (octet_cnt < AccDigits && data_dig) digit_acc = digit_acc * 10 + TsW'(data - AsciiZero);
      latest_oct = data;
      if (octet_cnt < CountSat) octet_cnt = octet_cnt + 1'b1;
    end
    if (last) begin
      made       = 1'b1;
      res.status = StBadTag;
      if (value_tag == TagUtcTime || value_tag == TagGenTime) begin
        res.status = StBadFormat;
        if (octet_cnt == ((value_tag == TagUtcTime) ? LenUtc : LenGen) &&
            latest_oct == AsciiZ && prior_dig_ok) begin
          res.status = StOk;
          res.stamp  = digit_acc;
          // two-digit year: 50 and up is 19YY, below is 20YY
          if (value_tag == TagUtcTime) begin
            yy         = digit_acc / TenPow10;
            year       = (yy >= 50) ? 1900 + yy : 2000 + yy;
            res.stamp  = TsW'(year * 64'd10000000000 + digit_acc % TenPow10);
          end
        end
      end
      octet_cnt    = '0;
      digit_acc    = '0;
      prior_dig_ok = 1'b1;
      latest_oct   = '0;
      value_tag    = '0;
    end
  endtask

  // Offer one beat, with an optional idle burst first, and wait for it
  task automatic drive_beat(input logic [7:0] tag, input logic [7:0] data, input bit pres,
                            input bit last, input bit typed, input stamp_t typed_res);
    stamp_t got;
    bit     made;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.tag_byte     <= tag;
    in_if.data_byte    <= data;
    in_if.byte_present <= pres;
    in_if.last_item    <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
    predict_stamp(tag, data, pres, last, made, got);
    if (made) stamp_q.push_back(typed ? typed_res : got);
  endtask

  // Send one time value; noisy adds stray empty beats and junk tags later on
  task automatic send_value(input logic [7:0] tag, input bit lead, input logic [7:0] octs[$],
                            input bit trail, input bit typed, input stamp_t typed_res,
                            input bit noisy);
    bit end_empty;
    end_empty = trail || (octs.size() == 0);
    if (lead) drive_beat(~tag, 8'($urandom_range(0, 255)), 1'b0, 1'b0, typed, typed_res);
    foreach (octs[i]) begin
      if (noisy && $urandom_range(0, 19) == 0)
        drive_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                   typed, typed_res);
      drive_beat((i == 0 || !noisy) ? tag : 8'($urandom_range(0, 255)), octs[i], 1'b1,
                 !end_empty && (i == octs.size() - 1), typed, typed_res);
    end
    if (end_empty)
      drive_beat(noisy ? 8'($urandom_range(0, 255)) : tag, 8'($urandom_range(0, 255)),
                 1'b0, 1'b1, typed, typed_res);
  endtask

  function automatic void flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0d, actual %0d", what, exp_v, act_v);
  endfunction

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (stamp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status %0d timestamp %0d",
                   out_if.status, out_if.timestamp);
      end else begin
        want = stamp_q.pop_front();
        if (out_if.status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(out_if.status));
        if (out_if.timestamp !== want.stamp)
          flag_mismatch("timestamp", 64'(want.stamp), 64'(out_if.timestamp));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] octs[$];
    logic [7:0] tag;
    stamp_t     row_res;
    int         kind;
    int         pos;
    bit         utc;
    bit         held_off;
    held_off = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.tag_byte     <= '0;
    in_if.data_byte    <= '0;
    in_if.byte_present <= 1'b0;
    in_if.last_item    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[r]) begin
      octs.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) octs.push_back(dir_rows[r].text[i]);
      row_res.status = dir_rows[r].status;
      row_res.stamp  = dir_rows[r].stamp;
      send_value(dir_rows[r].tag, dir_rows[r].lead, octs, dir_rows[r].trail,
                 dir_rows[r].typed, row_res, 1'b0);
    end

    // Random values: mostly well formed, some broken, some noise
    row_res = '0;
    while (beats_sent < BeatTarget) begin
      octs.delete();
      kind = $urandom_range(0, 9);
      utc  = $urandom_range(0, 1);
      tag  = utc ? TagUtcTime : TagGenTime;
      if (kind == 9) begin
        if ($urandom_range(0, 1) == 0) tag = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 20))
          octs.push_back(($urandom_range(0, 3) == 0) ? 8'(AsciiZero + $urandom_range(0, 9))
                                                      : 8'($urandom_range(0, 255)));
      end else begin
        repeat (utc ? 12 : 14) octs.push_back(8'(AsciiZero + $urandom_range(0, 9)));
        // bias some two-digit years onto the century split
        if (utc && $urandom_range(0, 3) == 0) begin
          octs[0] = ($urandom_range(0, 1) == 0) ? "4" : "5";
          octs[1] = (octs[0] == "4") ? "9" : "0";
        end
        octs.push_back(AsciiZ);
        if (kind >= 7) begin
          pos = $urandom_range(0, octs.size() - 1);
          case ($urandom_range(0, 3))
            0:       octs[pos] = 8'($urandom_range(0, 255));
            1:       octs.delete(pos);
            2:       octs.insert(pos, 8'(AsciiZero + $urandom_range(0, 9)));
            default: tag = 8'($urandom_range(0, 255));
          endcase
        end
      end
      send_value(tag, $urandom_range(0, 7) == 0, octs, $urandom_range(0, 5) == 0,
                 1'b0, row_res, 1'b1);
      if (!held_off && beats_sent >= HoldAt) begin
        held_off = 1'b1;
        hold_req = 1'b1;
      end
      if (beats_sent + QuietTail >= BeatTarget) idle_on = 1'b0;
    end
    in_if.valid <= 1'b0;

    // Drain
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && stamp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dtc_pkg.sv
sv/dtc_if.sv
sv/dtc_track.sv
sv/dtc_result.sv
sv/der_time_to_canonical_core.sv
test/tb_der_time_to_canonical_core.sv
